### design/min_priority_queue_top_assert.svh
// Assertion macros for the min priority queue checker.
// No dependencies; included by the checker file only.
`ifndef MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define MPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mpq_pkg.sv
// Shared types, codes and control structs for the min priority queue.
// No dependencies; used by every module of the block.
`default_nettype none

package mpq_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int VAL_W     = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_PEEK   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    ins_write;
    logic    scan_init;
    logic    scan_cmp;
    logic    shift_init;
    logic    shift_wr;
    logic    rd_issue;
    logic    dec_cnt;
    logic    load_out;
    logic    res_best;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic issue_done;
    logic rd_vld;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### design/mpq_ctrl.sv
// Controller state machine for the min priority queue.
// Depends on mpq_pkg; drives the datapath through mpq_pkg::cmd_t.
`default_nettype none

module mpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire mpq_pkg::op_t  in_op,
  input  wire mpq_pkg::sts_t sts,
  output mpq_pkg::cmd_t      cmd
);

  mpq_pkg::state_t  state_r, state_nxt;
  mpq_pkg::op_t     op_r, op_nxt;
  mpq_pkg::status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpq_pkg::S_IDLE;
      op_r    <= mpq_pkg::OP_INSERT;
      st_r    <= mpq_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    st_nxt         = st_r;
    in_tready      = 1'b0;
    cmd            = '0;
    cmd.res_status = st_r;
    cmd.res_best   = (st_r == mpq_pkg::ST_OK) &&
                     ((op_r == mpq_pkg::OP_REMOVE) || (op_r == mpq_pkg::OP_PEEK));
    case (state_r)
      mpq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_op;
          st_nxt    = mpq_pkg::ST_OK;
          state_nxt = mpq_pkg::S_DONE;
          case (in_op) inside
            mpq_pkg::OP_INSERT: begin
              if (sts.cnt_full) begin
                st_nxt = mpq_pkg::ST_FULL;
              end else begin
                cmd.ins_write = 1'b1;
              end
            end
            mpq_pkg::OP_REMOVE, mpq_pkg::OP_PEEK: begin
              if (sts.cnt_zero) begin
                st_nxt = mpq_pkg::ST_EMPTY;
              end else begin
                cmd.scan_init = 1'b1;
                state_nxt     = mpq_pkg::S_SCAN;
              end
            end
            default: begin
              st_nxt = mpq_pkg::ST_OK;
            end
          endcase
        end
      end
      mpq_pkg::S_SCAN: begin
        cmd.scan_cmp = 1'b1;
        cmd.rd_issue = !sts.issue_done;
        if (sts.issue_done && !sts.rd_vld) begin
          if (op_r == mpq_pkg::OP_REMOVE) begin
            cmd.shift_init = 1'b1;
            state_nxt      = mpq_pkg::S_SHIFT;
          end else begin
            state_nxt = mpq_pkg::S_DONE;
          end
        end
      end
      mpq_pkg::S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        cmd.rd_issue = !sts.issue_done;
        if (sts.issue_done && !sts.rd_vld) begin
          cmd.dec_cnt = 1'b1;
          state_nxt   = mpq_pkg::S_DONE;
        end
      end
      mpq_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = mpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/mpq_dp.sv
// Datapath for the min priority queue: entry memory, count, scan and shift, result beat.
// Depends on mpq_pkg; commanded by mpq_ctrl.
`default_nettype none

module mpq_dp #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mpq_pkg::cmd_t             cmd,
  output mpq_pkg::sts_t                  sts,
  input  wire logic [mpq_pkg::VAL_W-1:0] in_value,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [mpq_pkg::VAL_W-1:0]      out_min,
  output mpq_pkg::status_t               out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [mpq_pkg::VAL_W-1:0] mem [DEPTH];

  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             ptr_r, ptr_nxt;
  logic                      rd_vld_r;
  logic [AW-1:0]             rd_idx_r;
  logic [mpq_pkg::VAL_W-1:0] rd_data_r;
  logic [mpq_pkg::VAL_W-1:0] best_val_r;
  logic [AW-1:0]             best_idx_r;
  logic                      out_vld_r;
  logic [mpq_pkg::VAL_W-1:0] out_min_r;
  mpq_pkg::status_t          out_st_r;
  logic                      take_best;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins_write) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.dec_cnt) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    ptr_nxt = ptr_r;
    if (cmd.scan_init) begin
      ptr_nxt = '0;
    end else if (cmd.shift_init) begin
      ptr_nxt = CW'(best_idx_r) + CW'(1);
    end else if (cmd.rd_issue) begin
      ptr_nxt = ptr_r + CW'(1);
    end
  end

  assign take_best = cmd.scan_cmp && rd_vld_r &&
                     ((rd_idx_r == '0) || ($signed(rd_data_r) < $signed(best_val_r)));

  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      mem[cnt_r[AW-1:0]] <= in_value;
    end else if (cmd.shift_wr && rd_vld_r) begin
      mem[rd_idx_r - AW'(1)] <= rd_data_r;
    end
    rd_data_r <= mem[ptr_r[AW-1:0]];
    rd_idx_r  <= ptr_r[AW-1:0];
    if (take_best) begin
      best_val_r <= rd_data_r;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.load_out) begin
      out_min_r <= cmd.res_best ? best_val_r : '0;
      out_st_r  <= cmd.res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ptr_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      ptr_r    <= ptr_nxt;
      rd_vld_r <= cmd.rd_issue;
      if (cmd.load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.cnt_full   = (cnt_r == CW'(DEPTH));
  assign sts.issue_done = (ptr_r == cnt_r);
  assign sts.rd_vld     = rd_vld_r;
  assign sts.out_free   = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_min    = out_min_r;
  assign out_status = out_st_r;

endmodule

`default_nettype wire

### design/min_priority_queue_top.sv
// Top level of the min priority queue: controller plus datapath.
// Depends on mpq_pkg, mpq_ctrl and mpq_dp.
//
//   channel  direction  tdata             tuser
//   in_      slave      [31:0] value      [1:0] opcode
//   out_     master     [31:0] min_value  [1:0] status
//
// One item at a time; n is the number of stored entries when the item is accepted.
// Insert and the empty/full/unused cases go from accept straight to the done state.
// Peek scans n entries; remove also shifts later ones down. The entry memory has one
// read port, so the minimum scan and the close-up shift each move one entry a cycle.
// rst_n (synchronous) empties the queue. A stalled result beat holds; the next item
// is accepted while it waits, and its result waits for the output register.
`default_nettype none

module min_priority_queue_top #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] min_value
  output logic [1:0]       out_tuser   // [1:0] status
);

  mpq_pkg::cmd_t    cmd;
  mpq_pkg::sts_t    sts;
  mpq_pkg::status_t out_status;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_min    (out_tdata),
    .out_status (out_status)
  );

  assign out_tuser = out_status;

endmodule

`default_nettype wire

### design/mpq_checker.sv
// Port-level checker for the min priority queue, bound to the top level.
// Depends on mpq_pkg and min_priority_queue_top_assert.svh.
`default_nettype none

`include "min_priority_queue_top_assert.svh"

module mpq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  `MPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")
  `MPQ_ASSERT_NOW(a_err_zero, clk, rst_n, out_tvalid && (out_tuser != mpq_pkg::ST_OK), out_tdata == 32'd0, "nonzero data on error status")
  `MPQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while an item is in progress")

endmodule

bind min_priority_queue_top mpq_checker u_mpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
